// ===== hw/rtl/aavr_pkg.sv =====
// Package for the axis-angle vector rotator: payload types, CORDIC constants
// and the arctangent table. No dependencies.
`default_nettype none
package aavr_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int NUM_STAGES    = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int SIDX_W        = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

  localparam logic signed [33:0] PI30       = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI30  = 34'sd1686629713;
  localparam logic signed [33:0] GAIN30     = 34'sd652032874;
  localparam logic signed [33:0] ONE24      = 34'sd16777216;

  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] angle;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
  } out_item_t;

  // Rotation state carried from cell to cell.
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } cordic_t;

  function automatic logic signed [33:0] atan30(input logic [SIDX_W-1:0] i);
    logic signed [33:0] r;
    case (i)
      0: r = 34'sh03243F6A8;  1: r = 34'sh01DAC6705;  2: r = 34'sh00FADBAFC;
      3: r = 34'sh007F56EA6;  4: r = 34'sh003FEAB76;  5: r = 34'sh001FFD55B;
      6: r = 34'sh000FFFAAA;  7: r = 34'sh0007FFF55;  8: r = 34'sh0003FFFEA;
      9: r = 34'sh0001FFFFD; 10: r = 34'sh0000FFFFF; 11: r = 34'sh00007FFFF;
      12: r = 34'sh00003FFFF; 13: r = 34'sh00001FFFF; 14: r = 34'sh00000FFFF;
      15: r = 34'sh000007FFF; 16: r = 34'sh000003FFF; 17: r = 34'sh000001FFF;
      18: r = 34'sh000000FFF; 19: r = 34'sh0000007FF; 20: r = 34'sh0000003FF;
      21: r = 34'sh0000001FF; 22: r = 34'sh0000000FF; 23: r = 34'sh00000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/aavr_cordic_cell.sv =====
// One CORDIC rotation cell of the sine/cosine chain.
// Depends on aavr_pkg.
`default_nettype none
module aavr_cordic_cell (
  input  wire                          clk,
  input  wire                          en,
  input  wire  [aavr_pkg::SIDX_W-1:0]  idx,
  input  aavr_pkg::cordic_t            din,
  output aavr_pkg::cordic_t            dout
);
  import aavr_pkg::*;

  cordic_t nxt;
  logic signed [33:0] ys, xs, at;

  always_comb begin
    ys = din.y >>> idx;
    xs = din.x >>> idx;
    at = atan30(idx);
    if (!din.z[33]) begin
      nxt.x = din.x - ys;
      nxt.y = din.y + xs;
      nxt.z = din.z - at;
    end else begin
      nxt.x = din.x + ys;
      nxt.y = din.y - xs;
      nxt.z = din.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) dout <= nxt;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/aavr_combine.sv =====
// Rodrigues combine pipeline: dot, projection, cross product, final sum and
// saturation. Depends on aavr_pkg.
`default_nettype none
module aavr_combine (
  input  wire                  clk,
  input  wire                  en,
  input  aavr_pkg::in_item_t   din,    // item aligned to CORDIC output
  input  wire signed [33:0]    cos_in, // Q.24, sign applied
  input  wire signed [33:0]    sin_in,
  output aavr_pkg::out_item_t  dout
);
  import aavr_pkg::*;

  // stage 1: products
  logic signed [47:0] m0, m1, m2, k0a, k0b, k1a, k1b, k2a, k2b;
  logic signed [31:0] v1 [3];
  logic signed [15:0] a1 [3];
  logic signed [33:0] c1, s1;
  // stage 2: dot and cross rounded
  logic signed [35:0] dot2;
  logic signed [35:0] cr2 [3];
  logic signed [31:0] v2 [3];
  logic signed [15:0] a2 [3];
  logic signed [33:0] c2, s2;
  // stage 3: projection
  logic signed [52:0] p3 [3];
  logic signed [35:0] cr3 [3];
  logic signed [31:0] v3 [3];
  logic signed [33:0] c3, s3;
  // stage 4: three products per lane
  logic signed [67:0] q0 [3], q1 [3], q2 [3];

  logic signed [49:0] dsum;
  logic signed [48:0] csum [3];

  always_comb begin
    dsum = 50'(m0) + 50'(m1) + 50'(m2) + 50'sd8192;
    csum[0] = 49'(k0a) - 49'(k0b) + 49'sd8192;
    csum[1] = 49'(k1a) - 49'(k1b) + 49'sd8192;
    csum[2] = 49'(k2a) - 49'(k2b) + 49'sd8192;
  end

  logic signed [69:0] acc [3];
  logic signed [45:0] r [3];
  logic signed [31:0] sat [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc[j] = 70'(q0[j]) + 70'(q1[j]) + 70'(q2[j]) + 70'sd8388608;
      r[j]   = 46'(acc[j] >>> 24);
      if (r[j] > 46'sd2147483647)       sat[j] = 32'sh7FFFFFFF;
      else if (r[j] < -46'sd2147483648) sat[j] = 32'sh80000000;
      else                              sat[j] = r[j][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0 <= 48'(din.vec_x) * 48'(din.axis_x);
      m1 <= 48'(din.vec_y) * 48'(din.axis_y);
      m2 <= 48'(din.vec_z) * 48'(din.axis_z);
      k0a <= 48'(din.axis_y) * 48'(din.vec_z);  k0b <= 48'(din.axis_z) * 48'(din.vec_y);
      k1a <= 48'(din.axis_z) * 48'(din.vec_x);  k1b <= 48'(din.axis_x) * 48'(din.vec_z);
      k2a <= 48'(din.axis_x) * 48'(din.vec_y);  k2b <= 48'(din.axis_y) * 48'(din.vec_x);
      v1[0] <= din.vec_x; v1[1] <= din.vec_y; v1[2] <= din.vec_z;
      a1[0] <= din.axis_x; a1[1] <= din.axis_y; a1[2] <= din.axis_z;
      c1 <= cos_in; s1 <= sin_in;

      dot2 <= 36'(dsum >>> 14);
      for (int j = 0; j < 3; j++) begin
        cr2[j] <= 36'(csum[j] >>> 14);
        v2[j] <= v1[j]; a2[j] <= a1[j];
      end
      c2 <= c1; s2 <= s1;

      for (int j = 0; j < 3; j++) begin
        p3[j] <= 53'((53'(dot2) * 53'(a2[j]) + 53'sd8192) >>> 14);
        cr3[j] <= cr2[j]; v3[j] <= v2[j];
      end
      c3 <= c2; s3 <= s2;

      for (int j = 0; j < 3; j++) begin
        q0[j] <= 68'(v3[j]) * 68'(c3);
        q1[j] <= 68'(p3[j]) * 68'(ONE24 - c3);
        q2[j] <= 68'(cr3[j]) * 68'(s3);
      end

      dout.rot_x <= sat[0];
      dout.rot_y <= sat[1];
      dout.rot_z <= sat[2];
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/axis_angle_vector_rotate.sv =====
// Top level of the axis-angle vector rotator (Rodrigues formula).
// Stages from accepted input to valid output: 1 angle reduction,
// NUM_STAGES CORDIC cells, 1 rounding, 5 combine stages.
// Throughput: one transaction per cycle; the whole pipe holds while stalled.
// Reset: rst clears the valid bits only; no data state is kept.
// Depends on aavr_pkg, aavr_cordic_cell, aavr_combine.
`default_nettype none
module axis_angle_vector_rotate (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  aavr_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output aavr_pkg::out_item_t  out_data
);
  import aavr_pkg::*;

  localparam int LAT = NUM_STAGES + 7;

  // Whole pipe advances together; an empty output slot lets it move.
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], in_valid};
  end
  assign out_valid = vld[LAT-1];

  // Angle reduction into [-pi/2, pi/2].
  logic signed [33:0] t30;
  logic               neg0;
  cordic_t            c0;
  in_item_t           item0;
  always_comb t30 = 34'(in_data.angle) <<< 17;
  always_ff @(posedge clk) begin
    if (en) begin
      c0.x <= GAIN30;
      c0.y <= '0;
      if (t30 > HALF_PI30) begin
        c0.z <= t30 - PI30; neg0 <= 1'b1;
      end else if (t30 < -HALF_PI30) begin
        c0.z <= t30 + PI30; neg0 <= 1'b1;
      end else begin
        c0.z <= t30; neg0 <= 1'b0;
      end
      item0 <= in_data;
    end
  end

  // Chain of CORDIC cells, with the item and the sign flag carried alongside.
  cordic_t  ch   [NUM_STAGES+1];
  in_item_t itm  [NUM_STAGES+1];
  logic     ngs  [NUM_STAGES+1];
  assign ch[0]  = c0;
  assign itm[0] = item0;
  assign ngs[0] = neg0;

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cell
    aavr_cordic_cell u_cell (
      .clk  (clk),
      .en   (en),
      .idx  (SIDX_W'(g)),
      .din  (ch[g]),
      .dout (ch[g+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        itm[g+1] <= itm[g];
        ngs[g+1] <= ngs[g];
      end
    end
  end

  // Round to Q.24 and apply the half-turn sign.
  logic signed [33:0] cr, sr, cos_q, sin_q;
  in_item_t           item_r;
  always_comb begin
    cr = (ch[NUM_STAGES].x + 34'sd32) >>> 6;
    sr = (ch[NUM_STAGES].y + 34'sd32) >>> 6;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cos_q  <= ngs[NUM_STAGES] ? -cr : cr;
      sin_q  <= ngs[NUM_STAGES] ? -sr : sr;
      item_r <= itm[NUM_STAGES];
    end
  end

  aavr_combine u_comb (
    .clk    (clk),
    .en     (en),
    .din    (item_r),
    .cos_in (cos_q),
    .sin_in (sin_q),
    .dout   (out_data)
  );

  // Pipe must hold when the output is stalled.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("pipe advanced under output stall");
  a_lat: assert property (@(posedge clk) disable iff (rst)
    en && vld[LAT-2] |=> out_valid)
    else $error("valid lost in pipe");
  a_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("stall with empty output");
endmodule
`default_nettype wire
